@@ hw/rtl/wcd_pkg.sv @@
package wcd_pkg;

	// Weight store geometry.
	localparam int SIZE_CLASSES = 4;
	localparam int MATRIX_DEPTH = 64;
	localparam int SC_W         = $clog2(SIZE_CLASSES);
	localparam int POS_W        = $clog2(MATRIX_DEPTH);
	localparam int MEM_DEPTH    = SIZE_CLASSES * MATRIX_DEPTH;
	localparam int ADDR_W       = $clog2(MEM_DEPTH);
	localparam int WEIGHT_W     = 8;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd128;

	// Payload widths.
	localparam int COEFF_W = 16;
	localparam int SCALE_W = 16;
	localparam int SHIFT_W = 5;
	localparam int WSH_W   = 3;
	localparam int RND_W   = 31;

	// Result clipping limits.
	localparam logic signed [COEFF_W-1:0] RESULT_MIN = 16'sh8000;
	localparam logic signed [COEFF_W-1:0] RESULT_MAX = 16'sh7FFF;

	// Request action codes.
	localparam logic ACT_DEQUANT = 1'b0;
	localparam logic ACT_WRITE   = 1'b1;

	// Configuration register indexes (byte address bit 2).
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_SHIFT  = 1'b1;

	typedef struct packed {
		logic             weighted_enable;
		logic [WSH_W-1:0] weight_shift;
	} cfg_t;

	// Matrix entry picked by the downsampled coefficient position.
	function automatic logic [POS_W-1:0] weight_pos(input logic [1:0] sc,
			input logic [5:0] row, input logic [5:0] col);
		logic [POS_W-1:0] pos;
		begin
			case (sc)
				2'd0: pos = {2'b00, row[1:0], col[1:0]};
				2'd1: pos = {row[2:0], col[2:0]};
				2'd2: pos = {row[3:1], col[3:1]};
				2'd3: pos = {row[4:2], col[4:2]};
				default: pos = '0;
			endcase
			return pos;
		end
	endfunction

	// Rounding offset: half of the final shift step, zero when there is no shift.
	function automatic logic [RND_W-1:0] round_offset(input logic [SHIFT_W-1:0] sh);
		logic [RND_W-1:0] r;
		begin
			r = '0;
			if (sh != '0) begin
				r = RND_W'(1) << (sh - SHIFT_W'(1));
			end
			return r;
		end
	endfunction

endpackage

@@ hw/rtl/wcd_cfg_regs.sv @@
module wcd_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output wcd_pkg::cfg_t       cfg
);

	logic                       enable_q;
	logic [wcd_pkg::WSH_W-1:0]  wshift_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			wshift_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				wcd_pkg::REG_ENABLE: enable_q <= pwdata[0];
				wcd_pkg::REG_SHIFT:  wshift_q <= pwdata[wcd_pkg::WSH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (paddr[2])
			wcd_pkg::REG_ENABLE: prdata = {31'b0, enable_q};
			wcd_pkg::REG_SHIFT:  prdata = {{(32-wcd_pkg::WSH_W){1'b0}}, wshift_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.weighted_enable = enable_q;
	assign cfg.weight_shift    = wshift_q;

endmodule

@@ hw/rtl/wcd_weight_mem.sv @@
module wcd_weight_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [wcd_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [wcd_pkg::WEIGHT_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [wcd_pkg::ADDR_W-1:0]   rd_addr,
	output logic [wcd_pkg::WEIGHT_W-1:0] rd_weight
);

	logic [wcd_pkg::WEIGHT_W-1:0] mem [wcd_pkg::MEM_DEPTH];
	logic [wcd_pkg::MEM_DEPTH-1:0] valid_q;
	logic [wcd_pkg::WEIGHT_W-1:0] rdata_q;
	logic                         rvalid_q;

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Per-entry written flags; an unwritten entry reads as the flat weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_weight = rvalid_q ? rdata_q : wcd_pkg::WEIGHT_RESET;

endmodule

@@ hw/rtl/wcd_datapath.sv @@
module wcd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [wcd_pkg::COEFF_W-1:0]  coeff,
	input  logic [wcd_pkg::SCALE_W-1:0]         scale,
	input  logic [wcd_pkg::SHIFT_W-1:0]         shift,
	input  wcd_pkg::cfg_t                       cfg,
	input  logic [wcd_pkg::WEIGHT_W-1:0]        weight,
	output logic                                ready,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wcd_pkg::COEFF_W-1:0]  result_coeff
);

	localparam int P1_W  = 33;
	localparam int T_W   = 25;
	localparam int P2_W  = 42;
	localparam int SUM_W = 39;

	// Stage 1: request fields, weight arrives from the memory.
	logic                               v_s1;
	logic signed [wcd_pkg::COEFF_W-1:0] coeff_s1;
	logic [wcd_pkg::SCALE_W-1:0]        scale_s1;
	logic [wcd_pkg::SHIFT_W-1:0]        shift_s1;
	logic                               weighted_s1;
	logic [wcd_pkg::WSH_W-1:0]          wshift_s1;
	// Stage 2: first product.
	logic                               v_s2;
	logic signed [P1_W-1:0]             p1_s2;
	logic [wcd_pkg::SCALE_W-1:0]        scale_s2;
	logic [wcd_pkg::SHIFT_W-1:0]        shift_s2;
	logic                               weighted_s2;
	logic [wcd_pkg::WSH_W-1:0]          wshift_s2;
	// Stage 3: second product, scaled by 16.
	logic                               v_s3;
	logic signed [P2_W-1:0]             p2_s3;
	logic [wcd_pkg::SHIFT_W-1:0]        shift_s3;
	// Stage 4: rounded sum.
	logic                               v_s4;
	logic signed [SUM_W-1:0]            sum_s4;
	logic [wcd_pkg::SHIFT_W-1:0]        shift_s4;
	// Output register.
	logic                               out_valid_q;
	logic signed [wcd_pkg::COEFF_W-1:0] result_q;

	logic rdy_out, rdy4, rdy3, rdy2, rdy1;
	logic signed [16:0]        mul_b;
	logic signed [P1_W-1:0]    p1_d;
	logic signed [P1_W-1:0]    t_d;
	logic signed [P2_W-1:0]    p2_d;
	logic signed [SUM_W-1:0]   sum_d;
	logic signed [SUM_W-1:0]   shifted_d;
	logic signed [wcd_pkg::COEFF_W-1:0] clip_d;

	// A stage takes new data when it is empty or its successor moves.
	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy4    = !v_s4 || rdy_out;
	assign rdy3    = !v_s3 || rdy4;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign ready   = rdy1;

	// First multiply: coefficient by weight, or by scale without weighting.
	always_comb begin
		mul_b = weighted_s1 ? signed'({9'b0, weight}) : signed'({1'b0, scale_s1});
		p1_d  = P1_W'(coeff_s1) * P1_W'(mul_b);
	end

	// Second multiply by scale; the plain path is pre-scaled so the shift by four undoes it.
	always_comb begin
		t_d = p1_s2 >>> wshift_s2;
		if (weighted_s2) begin
			p2_d = P2_W'(signed'(t_d[T_W-1:0])) * P2_W'(signed'({1'b0, scale_s2}));
		end else begin
			p2_d = {{(P2_W-P1_W-4){p1_s2[P1_W-1]}}, p1_s2, 4'b0000};
		end
	end

	// Drop the four fraction bits and add the rounding offset.
	always_comb begin
		sum_d = signed'({p2_s3[P2_W-1], p2_s3[P2_W-1:4]})
			+ signed'({{(SUM_W-wcd_pkg::RND_W){1'b0}}, wcd_pkg::round_offset(shift_s3)});
	end

	// Final arithmetic shift and clip to signed 16 bits.
	always_comb begin
		shifted_d = sum_s4 >>> shift_s4;
		if (shifted_d > SUM_W'(wcd_pkg::RESULT_MAX)) begin
			clip_d = wcd_pkg::RESULT_MAX;
		end else if (shifted_d < SUM_W'(wcd_pkg::RESULT_MIN)) begin
			clip_d = wcd_pkg::RESULT_MIN;
		end else begin
			clip_d = shifted_d[wcd_pkg::COEFF_W-1:0];
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= load;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy4)    v_s4        <= v_s3;
			if (rdy_out) out_valid_q <= v_s4;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy1 && load) begin
			coeff_s1    <= coeff;
			scale_s1    <= scale;
			shift_s1    <= shift;
			weighted_s1 <= cfg.weighted_enable;
			wshift_s1   <= cfg.weight_shift;
		end
		if (rdy2 && v_s1) begin
			p1_s2       <= p1_d;
			scale_s2    <= scale_s1;
			shift_s2    <= shift_s1;
			weighted_s2 <= weighted_s1;
			wshift_s2   <= wshift_s1;
		end
		if (rdy3 && v_s2) begin
			p2_s3    <= p2_d;
			shift_s3 <= shift_s2;
		end
		if (rdy4 && v_s3) begin
			sum_s4   <= sum_d;
			shift_s4 <= shift_s3;
		end
		if (rdy_out && v_s4) begin
			result_q <= clip_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_coeff = result_q;

endmodule

@@ hw/rtl/weighted_coeff_dequantizer.sv @@
// Weighted coefficient dequantizer. Each request either writes one entry of the
// weight store (four 64-entry matrices of 8-bit weights, selected by size_class and
// weight_index) or dequantizes one coefficient. A request is taken every cycle while
// in_stall is low; a weight write finishes in the cycle it is accepted and yields no
// result, and a coefficient yields its result through a pipeline of one
// weight-memory read, two multiplier stages, a rounding add and a shift-and-clip
// stage. The input stalls only while the pipeline is full behind a stalled result.
// After reset every weight reads as 128 at once: per-entry written flags cover the
// store, so there is no clearing pass. A weight written by one request is seen by the
// very next coefficient request. Configuration registers sit at byte addresses 0
// (weighted_enable) and 4 (weight_shift) and are to be written only while idle.
module weighted_coeff_dequantizer (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Request channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [15:0] coeff,
	input  logic [15:0]        scale,
	input  logic [4:0]         shift,
	input  logic [1:0]         size_class,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic [5:0]         weight_index,
	input  logic [7:0]         weight_value,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] result_coeff
);

	wcd_pkg::cfg_t                  cfg;
	logic                           ready;
	logic                           accept;
	logic                           deq_load;
	logic                           wr_en;
	logic [wcd_pkg::ADDR_W-1:0]     wr_addr;
	logic [wcd_pkg::ADDR_W-1:0]     rd_addr;
	logic [wcd_pkg::WEIGHT_W-1:0]   weight;

	wcd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Request decode: writes go to the store, coefficients enter the pipeline.
	assign in_stall = !ready;
	assign accept   = in_valid && ready;
	assign wr_en    = accept && (action == wcd_pkg::ACT_WRITE);
	assign deq_load = accept && (action == wcd_pkg::ACT_DEQUANT);
	assign wr_addr  = {size_class, weight_index};
	assign rd_addr  = {size_class, wcd_pkg::weight_pos(size_class, row, col)};

	wcd_weight_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (weight_value),
		.rd_en     (deq_load),
		.rd_addr   (rd_addr),
		.rd_weight (weight)
	);

	wcd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (deq_load),
		.coeff        (coeff),
		.scale        (scale),
		.shift        (shift),
		.cfg          (cfg),
		.weight       (weight),
		.ready        (ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_coeff (result_coeff)
	);

endmodule

@@ hw/rtl/wcd_checker.sv @@
module wcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pready,
	input logic               in_valid,
	input logic               in_stall,
	input logic               action,
	input logic               out_valid,
	input logic               out_stall
);

	logic deq_accept;
	assign deq_accept = in_valid && !in_stall && (action == wcd_pkg::ACT_DEQUANT);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result withdrawn while stalled");

	// The request side stalls only when a result is held by the receiver.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without output back-pressure");

	// An accepted coefficient leads to a result offered after stages s1 to s4 and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		deq_accept |-> ##5 out_valid)
		else $error("no result five cycles after a coefficient request");

	// The configuration port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable) |-> pready)
		else $error("configuration access not ready");

endmodule

bind weighted_coeff_dequantizer wcd_checker u_wcd_checker (.*);
